FILE: hw/rtl/rtn_pkg.sv
package rtn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CRD_W     = 32;
    localparam int DIF_W     = CRD_W + 1;
    localparam int OP_W      = DIF_W + 1;
    localparam int PRD_W     = 2 * OP_W;
    localparam int CRS_W     = 2 * DIF_W;
    localparam int DET_W     = 100;
    localparam int QUO_W     = DET_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(QUO_W);
    localparam int COL_W     = 24;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_TRACE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_BG_RED   = 3'd3,
        CFG_BG_GREEN = 3'd4,
        CFG_BG_BLUE  = 3'd5
    } t_cfg_idx;

    localparam logic PH_CROSS = 1'b0;
    localparam logic PH_DOT   = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } t_item;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       any_hit;
        logic       scene_overflow;
    } t_result;

    typedef struct packed {
        logic       trace_init;
        logic       fill_we;
        logic       vtx_we;
        logic       col_we;
        logic       vtx_rd;
        logic [1:0] vidx;
        logic       prep;
        logic       mul_en;
        logic       mul_phase;
        logic [1:0] mul_vec;
        logic [1:0] mul_comp;
        logic       mul_term;
        logic       norm;
        logic       test;
        logic       div_step;
        logic       update;
        logic       emit;
        logic       overflow;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
    } t_dp_status;

endpackage

FILE: hw/rtl/rtn_ctrl.sv
module rtn_ctrl #(
    parameter int MAX_TRIANGLES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  rtn_pkg::t_dp_status  i_status,
    output logic                 o_busy,
    output rtn_pkg::t_dp_cmd     o_cmd,
    output logic [((MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1)-1:0] o_tri
);

    localparam int TIW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW  = $clog2(MAX_TRIANGLES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_PREP, S_MUL, S_DRAIN, S_NORM, S_TEST, S_DIV, S_UPDATE, S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [1:0]                      r_pending, n_pending;
    logic                            r_overflow, n_overflow;
    logic [TIW-1:0]                  r_tri, n_tri;
    logic [1:0]                      r_vidx, n_vidx;
    logic                            r_phase, n_phase;
    logic [1:0]                      r_vec, n_vec;
    logic [1:0]                      r_comp, n_comp;
    logic                            r_term, n_term;
    logic [rtn_pkg::DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic                            full;
    logic                            last_tri;

    assign full     = (r_count == CW'(MAX_TRIANGLES));
    assign last_tri = ((CW'(r_tri) + CW'(1)) == r_count);
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pending  = r_pending;
        n_overflow = r_overflow;
        n_tri      = r_tri;
        n_vidx     = r_vidx;
        n_phase    = r_phase;
        n_vec      = r_vec;
        n_comp     = r_comp;
        n_term     = r_term;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        o_cmd.overflow = r_overflow;
        o_tri      = r_tri;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_command)
                        rtn_pkg::CMD_CLEAR: begin
                            n_count    = '0;
                            n_pending  = '0;
                            n_overflow = 1'b0;
                        end
                        rtn_pkg::CMD_FILL: begin
                            o_cmd.fill_we = 1'b1;
                        end
                        rtn_pkg::CMD_APPEND: begin
                            o_tri        = r_count[TIW-1:0];
                            o_cmd.vidx   = r_pending;
                            o_cmd.vtx_we = !full;
                            if (r_pending == 2'd2) begin
                                n_pending = '0;
                                if (!full) begin
                                    o_cmd.col_we = 1'b1;
                                    n_count      = r_count + CW'(1);
                                end else begin
                                    n_overflow = 1'b1;
                                end
                            end else begin
                                n_pending = r_pending + 2'd1;
                            end
                        end
                        default: begin
                            o_cmd.trace_init = 1'b1;
                            n_tri  = '0;
                            n_vidx = '0;
                            n_state = (r_count == '0) ? S_DONE : S_LOAD;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.vtx_rd = 1'b1;
                o_cmd.vidx   = r_vidx;
                if (r_vidx == 2'd2) begin
                    n_vidx  = '0;
                    n_state = S_PREP;
                end else begin
                    n_vidx = r_vidx + 2'd1;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_phase = rtn_pkg::PH_CROSS;
                n_vec   = '0;
                n_comp  = '0;
                n_term  = 1'b0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_phase = r_phase;
                o_cmd.mul_vec   = r_vec;
                o_cmd.mul_comp  = r_comp;
                o_cmd.mul_term  = r_term;
                if (!r_term) begin
                    n_term = 1'b1;
                end else begin
                    n_term = 1'b0;
                    if (r_comp == 2'd2) begin
                        n_comp = '0;
                        if ((r_phase == rtn_pkg::PH_DOT) ? (r_vec == 2'd3) : (r_vec == 2'd2)) begin
                            n_vec = '0;
                            if (r_phase == rtn_pkg::PH_DOT) begin
                                n_state = S_DRAIN;
                            end else begin
                                n_phase = rtn_pkg::PH_DOT;
                            end
                        end else begin
                            n_vec = r_vec + 2'd1;
                        end
                    end else begin
                        n_comp = r_comp + 2'd1;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                if (i_status.hit) begin
                    n_div_cnt = '0;
                    n_state   = S_DIV;
                end else if (last_tri) begin
                    n_state = S_DONE;
                end else begin
                    n_tri   = r_tri + TIW'(1);
                    n_state = S_LOAD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == rtn_pkg::DIV_CNT_W'(rtn_pkg::QUO_W - 1)) begin
                    n_state = S_UPDATE;
                end else begin
                    n_div_cnt = r_div_cnt + rtn_pkg::DIV_CNT_W'(1);
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (last_tri) begin
                    n_state = S_DONE;
                end else begin
                    n_tri   = r_tri + TIW'(1);
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pending  <= '0;
            r_overflow <= 1'b0;
            r_tri      <= '0;
            r_vidx     <= '0;
            r_phase    <= rtn_pkg::PH_CROSS;
            r_vec      <= '0;
            r_comp     <= '0;
            r_term     <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pending  <= n_pending;
            r_overflow <= n_overflow;
            r_tri      <= n_tri;
            r_vidx     <= n_vidx;
            r_phase    <= n_phase;
            r_vec      <= n_vec;
            r_comp     <= n_comp;
            r_term     <= n_term;
            r_div_cnt  <= n_div_cnt;
        end
    end

`ifndef SYNTH
    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result beat not followed by idle");
    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == rtn_pkg::CMD_TRACE) |=> o_busy)
        else $error("trace accepted without going busy");
    a_overflow_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == rtn_pkg::CMD_APPEND && full
         && r_pending == 2'd2) |=> r_overflow)
        else $error("dropped triangle did not set overflow");
    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (CW'(r_tri) < r_count))
        else $error("triangle index past stored count");
`endif

endmodule

FILE: hw/rtl/rtn_dp.sv
module rtn_dp #(
    parameter int MAX_TRIANGLES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtn_pkg::t_item       i_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  rtn_pkg::t_dp_cmd     i_cmd,
    input  logic [((MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1)-1:0] i_tri,
    output rtn_pkg::t_dp_status  o_status,
    output rtn_pkg::t_result     o_result
);

    localparam int DEPTH = MAX_TRIANGLES * 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int CRD_W = rtn_pkg::CRD_W;
    localparam int DIF_W = rtn_pkg::DIF_W;
    localparam int OP_W  = rtn_pkg::OP_W;
    localparam int PRD_W = rtn_pkg::PRD_W;
    localparam int CRS_W = rtn_pkg::CRS_W;
    localparam int DET_W = rtn_pkg::DET_W;
    localparam int QUO_W = rtn_pkg::QUO_W;
    localparam int COL_W = rtn_pkg::COL_W;

    logic [3*CRD_W-1:0]        r_vmem [DEPTH];
    logic [COL_W-1:0]          r_cmem [MAX_TRIANGLES];

    logic signed [CRD_W-1:0]   r_org [3];
    logic [7:0]                r_bg_r, r_bg_g, r_bg_b;
    logic [COL_W-1:0]          r_fill;

    logic signed [CRD_W-1:0]   r_v [3][3];
    logic [COL_W-1:0]          r_tri_col;
    logic signed [DIF_W-1:0]   r_d [3];
    logic signed [DIF_W-1:0]   r_e1 [3];
    logic signed [DIF_W-1:0]   r_e2 [3];
    logic signed [DIF_W-1:0]   r_r [3];
    logic signed [CRS_W-1:0]   r_c [3][3];
    logic signed [CRS_W-1:0]   r_tmp;
    logic signed [DET_W-1:0]   r_acc;
    logic signed [DET_W-1:0]   r_det [4];

    logic signed [PRD_W-1:0]   r_prod;
    logic                      r_pv;
    logic                      r_pphase;
    logic [1:0]                r_pvec;
    logic [1:0]                r_pcomp;
    logic                      r_pterm;

    logic [DET_W-1:0]          r_rem;
    logic [QUO_W-1:0]          r_nq;
    logic [QUO_W-1:0]          r_best;
    logic                      r_any;
    logic [COL_W-1:0]          r_colour;

    logic [AW-1:0]             addr;
    logic [1:0]                j1, j2;
    logic signed [DIF_W-1:0]   va [3];
    logic signed [DIF_W-1:0]   vb [3];
    logic signed [DIF_W-1:0]   sel_a;
    logic signed [OP_W-1:0]    op_a, op_b;
    logic signed [CRS_W-1:0]   cs;
    logic [1:0]                cidx;
    logic signed [DET_W-1:0]   addend;
    logic                      hit;
    logic [DET_W:0]            bg_sum;
    logic [DET_W:0]            rem2;
    logic [DET_W:0]            diff;

    assign addr = (AW'(i_tri) << 1) + AW'(i_tri) + AW'(i_cmd.vidx);

    always_comb begin
        unique case (i_cmd.mul_comp)
            2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
            2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
            default: begin j1 = 2'd0; j2 = 2'd1; end
        endcase
        unique case (i_cmd.mul_vec)
            2'd0:    begin va = r_e2; vb = r_d;  end
            2'd1:    begin va = r_d;  vb = r_e1; end
            default: begin va = r_e1; vb = r_e2; end
        endcase
        unique case (i_cmd.mul_vec)
            2'd0, 2'd1: cidx = 2'd0;
            2'd2:       cidx = 2'd1;
            default:    cidx = 2'd2;
        endcase
        cs = r_c[cidx][i_cmd.mul_comp];
        if (i_cmd.mul_phase == rtn_pkg::PH_CROSS) begin
            op_a = OP_W'(i_cmd.mul_term ? va[j2] : va[j1]);
            op_b = OP_W'(i_cmd.mul_term ? vb[j1] : vb[j2]);
        end else begin
            sel_a = (i_cmd.mul_vec == 2'd0) ? r_e1[i_cmd.mul_comp] : r_r[i_cmd.mul_comp];
            op_a  = OP_W'(sel_a);
            if (i_cmd.mul_term) begin
                op_b = OP_W'($signed(cs[CRS_W-1:DIF_W]));
            end else begin
                op_b = $signed({1'b0, cs[DIF_W-1:0]});
            end
        end
        if (i_cmd.mul_phase == rtn_pkg::PH_CROSS) begin
            sel_a = '0;
        end else begin
            sel_a = (i_cmd.mul_vec == 2'd0) ? r_e1[i_cmd.mul_comp] : r_r[i_cmd.mul_comp];
        end
    end

    assign addend = r_pterm ? $signed({r_prod[DET_W-DIF_W-1:0], {DIF_W{1'b0}}})
                            : DET_W'(r_prod);

    // hit window on the sign-normalized determinants
    assign bg_sum = (DET_W+1)'(r_det[1]) + (DET_W+1)'(r_det[2]);
    assign hit = (r_det[0] != '0)
              && !r_det[1][DET_W-1] && (r_det[1] != '0) && (r_det[1] < r_det[0])
              && !r_det[2][DET_W-1] && (r_det[2] != '0) && (r_det[2] < r_det[0])
              && (bg_sum < (DET_W+1)'(r_det[0]))
              && !r_det[3][DET_W-1] && (r_det[3] != '0);
    assign o_status.hit = hit;

    assign rem2 = {r_rem, r_nq[QUO_W-1]};
    assign diff = rem2 - {1'b0, r_det[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_bg_r   <= '0;
            r_bg_g   <= '0;
            r_bg_b   <= '0;
            r_fill   <= '0;
            r_pv     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtn_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                    rtn_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                    rtn_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                    rtn_pkg::CFG_BG_RED:   r_bg_r   <= i_cfg_data[7:0];
                    rtn_pkg::CFG_BG_GREEN: r_bg_g   <= i_cfg_data[7:0];
                    rtn_pkg::CFG_BG_BLUE:  r_bg_b   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.fill_we) begin
                r_fill <= {i_item.value_x[7:0], i_item.value_y[7:0], i_item.value_z[7:0]};
            end
            r_pv <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_we) begin
            r_vmem[addr] <= {i_item.value_x, i_item.value_y, i_item.value_z};
        end
        if (i_cmd.col_we) begin
            r_cmem[i_tri] <= r_fill;
        end
        if (i_cmd.vtx_rd) begin
            r_v[i_cmd.vidx][0] <= $signed(r_vmem[addr][3*CRD_W-1:2*CRD_W]);
            r_v[i_cmd.vidx][1] <= $signed(r_vmem[addr][2*CRD_W-1:CRD_W]);
            r_v[i_cmd.vidx][2] <= $signed(r_vmem[addr][CRD_W-1:0]);
        end
        if (i_cmd.vtx_rd && i_cmd.vidx == 2'd0) begin
            r_tri_col <= r_cmem[i_tri];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trace_init) begin
            r_d[0]   <= DIF_W'(i_item.value_x);
            r_d[1]   <= DIF_W'(i_item.value_y);
            r_d[2]   <= DIF_W'(i_item.value_z);
            r_any    <= 1'b0;
            r_colour <= {r_bg_r, r_bg_g, r_bg_b};
        end
        if (i_cmd.prep) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= DIF_W'(r_v[1][i]) - DIF_W'(r_v[0][i]);
                r_e2[i] <= DIF_W'(r_v[2][i]) - DIF_W'(r_v[0][i]);
                r_r[i]  <= DIF_W'(r_org[i]) - DIF_W'(r_v[0][i]);
            end
        end
        r_prod   <= op_a * op_b;
        r_pphase <= i_cmd.mul_phase;
        r_pvec   <= i_cmd.mul_vec;
        r_pcomp  <= i_cmd.mul_comp;
        r_pterm  <= i_cmd.mul_term;
        if (r_pv) begin
            if (r_pphase == rtn_pkg::PH_CROSS) begin
                if (!r_pterm) begin
                    r_tmp <= r_prod[CRS_W-1:0];
                end else begin
                    r_c[r_pvec][r_pcomp] <= r_tmp - $signed(r_prod[CRS_W-1:0]);
                end
            end else begin
                if (r_pcomp == 2'd0 && !r_pterm) begin
                    r_acc <= addend;
                end else begin
                    r_acc <= r_acc + addend;
                end
                if (r_pcomp == 2'd2 && r_pterm) begin
                    r_det[r_pvec] <= r_acc + addend;
                end
            end
        end
        if (i_cmd.norm && r_det[0][DET_W-1]) begin
            for (int i = 0; i < 4; i++) begin
                r_det[i] <= -r_det[i];
            end
        end
        if (i_cmd.test) begin
            r_rem <= '0;
            r_nq  <= {r_det[3], {rtn_pkg::FRAC_BITS{1'b0}}};
        end
        if (i_cmd.div_step) begin
            if (!diff[DET_W]) begin
                r_rem <= diff[DET_W-1:0];
                r_nq  <= {r_nq[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= rem2[DET_W-1:0];
                r_nq  <= {r_nq[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.update && (!r_any || r_nq < r_best)) begin
            r_best   <= r_nq;
            r_any    <= 1'b1;
            r_colour <= r_tri_col;
        end
    end

    assign o_result.pixel_red      = r_colour[23:16];
    assign o_result.pixel_green    = r_colour[15:8];
    assign o_result.pixel_blue     = r_colour[7:0];
    assign o_result.any_hit        = r_any;
    assign o_result.scene_overflow = i_cmd.overflow;

endmodule

FILE: hw/rtl/ray_triangle_nearest_hit.sv
// Clear, fill and append items are handled in the idle state; the block stays ready.
// A trace walks the stored triangles one at a time on one shared 34x34 multiplier:
// each hit adds a 116-step bit-serial divide for t.
// The result beat comes the cycle after the last triangle; an empty scene goes straight to the result beat.
// The result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset clears control, config and fill colour; stores are not cleared.
module ray_triangle_nearest_hit #(
    parameter int MAX_TRIANGLES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rtn_pkg::t_item    i_item,
    output logic              o_result_valid,
    output rtn_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int TIW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    rtn_pkg::t_dp_cmd    dp_cmd;
    rtn_pkg::t_dp_status dp_status;
    logic [TIW-1:0]      tri_idx;

    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = dp_cmd.emit;

    rtn_ctrl #(
        .MAX_TRIANGLES(MAX_TRIANGLES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_status  (dp_status),
        .o_busy    (busy),
        .o_cmd     (dp_cmd),
        .o_tri     (tri_idx)
    );

    rtn_dp #(
        .MAX_TRIANGLES(MAX_TRIANGLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .i_tri       (tri_idx),
        .o_status    (dp_status),
        .o_result    (o_result)
    );

endmodule
